// ----- sv/lmu_pkg.sv -----
// shared constants, tables and helpers for the lattice metropolis update block
`timescale 1ns / 1ps
package lmu_pkg;

    // default geometry
    localparam int SIDE_DEF       = 256;
    localparam int ANGLE_BITS_DEF = 16;

    // operation codes on the mode field
    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_ATTEMPT = 2'd1;
    localparam logic [1:0] MODE_READ    = 2'd2;

    // configuration reset value, 2.0 in Q8.8
    localparam logic [15:0] INV_TEMP_RST = 16'd512;

    // cosine table geometry
    localparam int TBITS = 10;

    // fixed-point constants
    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam longint unsigned ONE30  = 64'd1 << 30;
    localparam logic [31:0] LOG2E_Q16  = 32'd94548;
    localparam logic [31:0] LN2_Q30    = 32'd744261118;

    // shared multiplier operand widths
    localparam int MUL_AW = 33;
    localparam int MUL_BW = 32;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    // floor(2^31 / k) for the series divisors 1..7
    typedef logic [31:0] recip_tab_t [8];
    localparam recip_tab_t RECIP_TAB = '{
        32'd0, 32'd2147483648, 32'd1073741824, 32'd715827882,
        32'd536870912, 32'd429496729, 32'd357913941, 32'd306783378
    };

    // quarter wave of cos in Q12, 257 points
    typedef logic [12:0] qcos_t [257];

    function automatic qcos_t build_qcos();
        qcos_t tab;
        longint unsigned x;
        longint unsigned y;
        longint unsigned t;
        longint unsigned p;
        for (int m = 0; m <= 256; m++) begin
            x = (longint'(m) * PI_Q30) >> 9;
            y = (x * x) >> 30;
            t = ONE30;
            for (int k = 0; k < 4; k++) begin
                p = (y * t) >> 30;
                case (k)
                    0: p = p / 56;
                    1: p = p / 30;
                    2: p = p / 12;
                    default: p = p / 2;
                endcase
                t = (p >= ONE30) ? 64'd0 : ONE30 - p;
            end
            tab[m] = 13'((t + (64'd1 << 17)) >> 18);
        end
        return tab;
    endfunction

    localparam qcos_t QCOS = build_qcos();

    // coordinate modulo side by shifted compare-subtract, value below 256
    function automatic logic [7:0] wrap_coord(input logic [7:0] v, input int side);
        int acc;
        acc = int'(v);
        for (int k = 7; k >= 0; k--) begin
            if (acc >= (side << k))
                acc = acc - (side << k);
        end
        return acc[7:0];
    endfunction

endpackage

// ----- sv/lmu_ram.sv -----
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module lmu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/lmu_mul.sv -----
// shared unsigned multiplier with registered product
`timescale 1ns / 1ps
module lmu_mul
    import lmu_pkg::*;
(
    input  logic              clk,
    input  logic [MUL_AW-1:0] a,
    input  logic [MUL_BW-1:0] b,
    output logic [MUL_PW-1:0] prod
);

    // one product per cycle
    always_ff @(posedge clk)
    begin
        prod <= MUL_PW'(a) * MUL_PW'(b);
    end

endmodule

// ----- sv/lmu_bond.sv -----
// bond cosine difference: cos(2(new-nb)) - cos(2(old-nb)) in Q12
`timescale 1ns / 1ps
module lmu_bond
    import lmu_pkg::*;
#(
    parameter int AW = ANGLE_BITS_DEF
) (
    input  logic [AW-1:0]      old_angle,
    input  logic [AW-1:0]      new_angle,
    input  logic [AW-1:0]      nb_angle,
    output logic signed [14:0] diff
);

    localparam int TUP_SH = (AW >= TBITS) ? AW - TBITS : 0;
    localparam int TDN_SH = (AW >= TBITS) ? 0 : TBITS - AW;

    function automatic logic signed [13:0] cos_of(input logic [AW-1:0] a,
                                                   input logic [AW-1:0] b);
        logic [AW-1:0]    d;
        logic [AW+9:0]    w;
        logic [9:0]       idx;
        logic [8:0]       ix;
        logic [12:0]      mag;
        d   = a - b;
        w   = ({10'b0, d[AW-2:0], 1'b0} >> TUP_SH) << TDN_SH;
        idx = w[9:0];
        ix  = idx[8] ? (9'd256 - {1'b0, idx[7:0]}) : {1'b0, idx[7:0]};
        mag = QCOS[ix];
        // second and third quadrants are negative
        if (idx[9] ^ idx[8])
            return -$signed({1'b0, mag});
        else
            return $signed({1'b0, mag});
    endfunction

    // two table reads and one subtract
    always_comb
    begin
        diff = 15'(cos_of(new_angle, nb_angle)) - 15'(cos_of(old_angle, nb_angle));
    end

endmodule

// ----- sv/lattice_metropolis_update.sv -----
// top level: lattice store, energy sequencer and acceptance test
//
//  channel  | handshake                | payload
//  ---------+--------------------------+---------------------------------------------
//  in       | in_valid / in_ready      | mode, row, col, load_angle, perturbation,
//           |                          | uniform_draw
//  out      | out_valid / out_ready    | accepted, site_angle, energy_change
//  cfg      | cfg_we                   | cfg_wdata (inv_temp)
//
// an attempt whose energy does not rise is kept at once; one whose energy rises needs
// the boltzmann factor, a series of 7 terms on the shared multiplier; a factor that
// underflows ends the attempt early, and the move is then kept only for a zero draw.
// the lattice ram has one read port, so the site and its four neighbors are read in
// turn. in_ready is high only while idle; a finished beat waits in the output register,
// and a new item is taken meanwhile. no clearing pass after reset.
`timescale 1ns / 1ps
module lattice_metropolis_update
    import lmu_pkg::*;
#(
    parameter int SIDE       = SIDE_DEF,
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         mode,
    input  logic [7:0]         row,
    input  logic [7:0]         col,
    input  logic [15:0]        load_angle,
    input  logic signed [15:0] perturbation,
    input  logic [15:0]        uniform_draw,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               accepted,
    output logic [15:0]        site_angle,
    output logic signed [15:0] energy_change,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata
);

    localparam int AW     = ANGLE_BITS;
    localparam int RB     = $clog2(SIDE);
    localparam int ADDR_W = 2 * RB;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int UP_SH  = (AW >= 16) ? AW - 16 : 0;
    localparam int DN_SH  = (AW >= 16) ? 0 : 16 - AW;
    localparam logic [RB-1:0] LAST = RB'(SIDE - 1);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_READ   = 11'b000_0000_0010,
        S_ENERGY = 11'b000_0000_0100,
        S_MX     = 11'b000_0000_1000,
        S_MY     = 11'b000_0001_0000,
        S_MZ     = 11'b000_0010_0000,
        S_ML     = 11'b000_0100_0000,
        S_MP     = 11'b000_1000_0000,
        S_MQ     = 11'b001_0000_0000,
        S_MT     = 11'b010_0000_0000,
        S_MF     = 11'b100_0000_0000
    } state_t;

    // write and done share the sequencer through two flags
    typedef struct packed {
        logic write;
        logic done;
    } tail_t;

    state_t               state_reg, state_next;
    tail_t                tail_reg, tail_next;
    logic [1:0]           mode_reg, mode_next;
    logic [RB-1:0]        row_reg, row_next;
    logic [RB-1:0]        col_reg, col_next;
    logic [AW-1:0]        step_reg, step_next;
    logic [15:0]          draw_reg, draw_next;
    logic [AW-1:0]        old_reg, old_next;
    logic [AW-1:0]        nw_reg, nw_next;
    logic [AW-1:0]        fin_reg, fin_next;
    logic [2:0]           cnt_reg, cnt_next;
    logic signed [16:0]   sum_reg, sum_next;
    logic signed [18:0]   de_reg, de_next;
    logic                 acc_reg, acc_next;
    logic [4:0]           n_reg, n_next;
    logic [29:0]          z_reg, z_next;
    logic [30:0]          t_reg, t_next;
    logic [30:0]          pr_reg, pr_next;
    logic [2:0]           k_reg, k_next;
    logic [15:0]          inv_temp_reg;
    logic                 out_valid_reg, out_valid_next;
    logic                 accepted_reg, accepted_next;
    logic [15:0]          site_angle_reg, site_angle_next;
    logic [15:0]          energy_change_reg, energy_change_next;

    logic [MUL_AW-1:0]    mul_a;
    logic [MUL_BW-1:0]    mul_b;
    logic [MUL_PW-1:0]    prod;
    logic                 ram_we;
    logic [ADDR_W-1:0]    raddr;
    logic [AW-1:0]        rdata;
    logic signed [14:0]   bond_diff;

    logic [RB+7:0]        row_w, col_w;
    logic [AW+15:0]       load_w, pert_w, out_w;
    logic [RB-1:0]        row_p, row_m, col_p, col_m;
    logic signed [18:0]   sum_x, de_calc, de_adj;
    logic [30:0]          q0, qv, factor;
    logic [33:0]          qk, rem;

    // input conversions to lattice precision
    always_comb
    begin
        row_w  = {{RB{1'b0}}, wrap_coord(row, SIDE)};
        col_w  = {{RB{1'b0}}, wrap_coord(col, SIDE)};
        load_w = ({{AW{1'b0}}, load_angle} << UP_SH) >> DN_SH;
        pert_w = ({{AW{perturbation[15]}}, perturbation} << UP_SH) >> DN_SH;
        out_w  = ({16'b0, fin_reg} >> UP_SH) << DN_SH;
    end

    // wrapped neighbor coordinates
    always_comb
    begin
        row_p = (row_reg == LAST) ? '0 : row_reg + 1'b1;
        row_m = (row_reg == '0) ? LAST : row_reg - 1'b1;
        col_p = (col_reg == LAST) ? '0 : col_reg + 1'b1;
        col_m = (col_reg == '0) ? LAST : col_reg - 1'b1;
    end

    // read address: site, then four neighbors
    always_comb
    begin
        case (cnt_reg)
            3'd1:    raddr = {row_p, col_reg};
            3'd2:    raddr = {row_m, col_reg};
            3'd3:    raddr = {row_reg, col_p};
            3'd4:    raddr = {row_reg, col_m};
            default: raddr = {row_reg, col_reg};
        endcase
    end

    assign ram_we = tail_reg.write;

    lmu_ram #(
        .WIDTH (AW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr ({row_reg, col_reg}),
        .wdata (fin_reg),
        .raddr (raddr),
        .rdata (rdata)
    );

    lmu_bond #(
        .AW (AW)
    ) u_bond (
        .old_angle (old_reg),
        .new_angle (nw_reg),
        .nb_angle  (rdata),
        .diff      (bond_diff)
    );

    lmu_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // energy and series arithmetic around the shared multiplier
    always_comb
    begin
        sum_x   = {{2{sum_reg[16]}}, sum_reg};
        de_calc = -(sum_x + (sum_x <<< 1));
        de_adj  = de_reg + ((de_reg < 0) ? 19'sd3 : 19'sd0);
        q0      = prod[61:31];
        qk      = 34'(q0) * 34'(k_reg);
        rem     = {3'b0, pr_reg} - qk;
        qv      = (rem >= 34'(k_reg)) ? q0 + 1'b1 : q0;
        factor  = t_reg >> (6'd14 + 6'(n_reg));
    end

    // sequencer
    always_comb
    begin
        state_next         = state_reg;
        tail_next          = tail_reg;
        mode_next          = mode_reg;
        row_next           = row_reg;
        col_next           = col_reg;
        step_next          = step_reg;
        draw_next          = draw_reg;
        old_next           = old_reg;
        nw_next            = nw_reg;
        fin_next           = fin_reg;
        cnt_next           = cnt_reg;
        sum_next           = sum_reg;
        de_next            = de_reg;
        acc_next           = acc_reg;
        n_next             = n_reg;
        z_next             = z_reg;
        t_next             = t_reg;
        pr_next            = pr_reg;
        k_next             = k_reg;
        out_valid_next     = out_valid_reg;
        accepted_next      = accepted_reg;
        site_angle_next    = site_angle_reg;
        energy_change_next = energy_change_reg;
        mul_a              = '0;
        mul_b              = '0;
        in_ready           = 1'b0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        if (tail_reg.write) begin
            // write-back cycle
            tail_next.write = 1'b0;
            tail_next.done  = 1'b1;
        end else if (tail_reg.done) begin
            // result into the output register once it is free
            if (!out_valid_reg || out_ready) begin
                out_valid_next     = 1'b1;
                accepted_next      = acc_reg;
                site_angle_next    = out_w[15:0];
                energy_change_next = de_adj[17:2];
                tail_next.done     = 1'b0;
                state_next         = S_IDLE;
            end
        end else begin
            case (state_reg)
                S_IDLE: begin
                    in_ready = 1'b1;
                    if (in_valid) begin
                        mode_next = mode;
                        row_next  = row_w[RB-1:0];
                        col_next  = col_w[RB-1:0];
                        step_next = pert_w[AW-1:0];
                        draw_next = uniform_draw;
                        fin_next  = load_w[AW-1:0];
                        cnt_next  = '0;
                        sum_next  = '0;
                        de_next   = '0;
                        acc_next  = 1'b0;
                        if (mode == MODE_LOAD) begin
                            tail_next.write = 1'b1;
                            state_next      = S_READ;
                        end else begin
                            state_next = S_READ;
                        end
                    end
                end
                S_READ: begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == 3'd1) begin
                        old_next = rdata;
                        nw_next  = rdata + step_reg;
                        fin_next = rdata;
                        if (mode_reg != MODE_ATTEMPT)
                            tail_next.done = 1'b1;
                    end
                    if (cnt_reg >= 3'd2)
                        sum_next = sum_reg + 17'(bond_diff);
                    if (cnt_reg == 3'd5)
                        state_next = S_ENERGY;
                end
                S_ENERGY: begin
                    de_next = de_calc;
                    if (de_calc <= 0) begin
                        acc_next        = 1'b1;
                        fin_next        = nw_reg;
                        tail_next.write = 1'b1;
                    end else begin
                        state_next = S_MX;
                    end
                end
                S_MX: begin
                    mul_a      = MUL_AW'(de_reg[16:0]);
                    mul_b      = MUL_BW'(inv_temp_reg);
                    state_next = S_MY;
                end
                S_MY: begin
                    mul_a      = prod[32:0];
                    mul_b      = LOG2E_Q16;
                    state_next = S_MZ;
                end
                S_MZ: begin
                    if ((|prod[64:43]) || (prod[42:38] >= 5'd17)) begin
                        // factor underflows to zero
                        if (draw_reg == '0) begin
                            acc_next        = 1'b1;
                            fin_next        = nw_reg;
                            tail_next.write = 1'b1;
                        end else begin
                            tail_next.done = 1'b1;
                        end
                    end else begin
                        n_next     = prod[42:38];
                        mul_a      = MUL_AW'(prod[37:16]);
                        mul_b      = LN2_Q30;
                        state_next = S_ML;
                    end
                end
                S_ML: begin
                    z_next     = prod[51:22];
                    t_next     = 31'(ONE30);
                    k_next     = 3'd7;
                    state_next = S_MP;
                end
                S_MP: begin
                    mul_a      = MUL_AW'(z_reg);
                    mul_b      = MUL_BW'(t_reg);
                    state_next = S_MQ;
                end
                S_MQ: begin
                    pr_next    = prod[60:30];
                    mul_a      = MUL_AW'(prod[60:30]);
                    mul_b      = RECIP_TAB[k_reg];
                    state_next = S_MT;
                end
                S_MT: begin
                    t_next = (qv >= 31'(ONE30)) ? '0 : 31'(ONE30) - qv;
                    k_next = k_reg - 1'b1;
                    state_next = (k_reg == 3'd1) ? S_MF : S_MP;
                end
                S_MF: begin
                    if (factor >= {15'b0, draw_reg}) begin
                        acc_next        = 1'b1;
                        fin_next        = nw_reg;
                        tail_next.write = 1'b1;
                    end else begin
                        tail_next.done = 1'b1;
                    end
                end
                default: state_next = S_IDLE;
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            tail_reg      <= '0;
            out_valid_reg <= 1'b0;
            inv_temp_reg  <= INV_TEMP_RST;
        end else begin
            state_reg     <= state_next;
            tail_reg      <= tail_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                inv_temp_reg <= cfg_wdata;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        mode_reg          <= mode_next;
        row_reg           <= row_next;
        col_reg           <= col_next;
        step_reg          <= step_next;
        draw_reg          <= draw_next;
        old_reg           <= old_next;
        nw_reg            <= nw_next;
        fin_reg           <= fin_next;
        cnt_reg           <= cnt_next;
        sum_reg           <= sum_next;
        de_reg            <= de_next;
        acc_reg           <= acc_next;
        n_reg             <= n_next;
        z_reg             <= z_next;
        t_reg             <= t_next;
        pr_reg            <= pr_next;
        k_reg             <= k_next;
        accepted_reg      <= accepted_next;
        site_angle_reg    <= site_angle_next;
        energy_change_reg <= energy_change_next;
    end

    assign out_valid     = out_valid_reg;
    assign accepted      = accepted_reg;
    assign site_angle    = site_angle_reg;
    assign energy_change = energy_change_reg;

endmodule

// ----- sv/lmu_checker.sv -----
// port-level checks for the lattice metropolis update block
`timescale 1ns / 1ps
module lmu_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic               accepted,
    input logic [15:0]        site_angle,
    input logic signed [15:0] energy_change
);

    // one item at a time: busy right after an input beat
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("in_ready high right after an input beat");

    // a fresh result frees the input side in the same cycle
    a_ready_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result shown while input side still busy");

    // a falling energy is always kept
    a_downhill_kept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && energy_change[15] |-> accepted)
        else $error("move with negative energy change rejected");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(site_angle)
            && $stable(energy_change) && $stable(accepted))
        else $error("stalled result beat changed");

endmodule

bind lattice_metropolis_update lmu_checker u_lmu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .accepted      (accepted),
    .site_angle    (site_angle),
    .energy_change (energy_change)
);

// ----- verif/tb_top.sv -----
// testbench for the lattice metropolis update block: predictor, driver and monitor
`timescale 1ns / 1ps
module tb_top;
    import lmu_pkg::*;

    localparam int N_SIDE = 256;

    typedef struct packed {
        logic [1:0]         mode;
        logic [7:0]         row;
        logic [7:0]         col;
        logic [15:0]        load_angle;
        logic signed [15:0] perturbation;
        logic [15:0]        uniform_draw;
    } move_t;

    typedef struct packed {
        logic               accepted;
        logic [15:0]        site_angle;
        logic signed [15:0] energy_change;
    } site_result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         mode;
    logic [7:0]         row;
    logic [7:0]         col;
    logic [15:0]        load_angle;
    logic signed [15:0] perturbation;
    logic [15:0]        uniform_draw;
    logic               out_valid;
    logic               out_ready;
    logic               accepted;
    logic [15:0]        site_angle;
    logic signed [15:0] energy_change;
    logic               cfg_we;
    logic [15:0]        cfg_wdata;

    lattice_metropolis_update dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode), .row(row), .col(col), .load_angle(load_angle),
        .perturbation(perturbation), .uniform_draw(uniform_draw),
        .out_valid(out_valid), .out_ready(out_ready),
        .accepted(accepted), .site_angle(site_angle), .energy_change(energy_change),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    // predictor state
    logic [15:0]  grid_angle [N_SIDE*N_SIDE];
    logic [15:0]  temp_recip;
    int           cos_q12 [1024];

    move_t        move_queue [$];
    site_result_t expected_results [$];
    int           error_count;
    int           result_count;
    int           send_idle_pct;
    int           recv_stall_pct;
    bit           recv_hold;
    int           recv_hold_cycles;
    int           attempt_count;
    int           accept_count;

    // clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // own quarter wave cos, series in Q30
    function automatic int cos_quarter(int m);
        longint unsigned x, y, t, p;
        longint unsigned dv [4];
        dv = '{56, 30, 12, 2};
        x = (longint'(m) * 64'd3373259426) / 512;
        y = (x * x) >> 30;
        t = 64'd1 << 30;
        for (int k = 0; k < 4; k++)
        begin
            p = ((y * t) >> 30) / dv[k];
            t = (p >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - p;
        end
        return int'((t + (64'd1 << 17)) >> 18);
    endfunction

    function automatic void fill_cos_table();
        int q, r;
        for (int i = 0; i < 1024; i++)
        begin
            q = i >> 8;
            r = i & 255;
            case (q)
                0: cos_q12[i] = cos_quarter(r);
                1: cos_q12[i] = -cos_quarter(256 - r);
                2: cos_q12[i] = -cos_quarter(r);
                default: cos_q12[i] = cos_quarter(256 - r);
            endcase
        end
    endfunction

    // bond energy in Q14
    function automatic int bond_q14(logic [15:0] a, logic [15:0] b);
        logic [15:0] d2;
        d2 = (a - b) << 1;
        return -4096 - 3 * cos_q12[d2[15:6]];
    endfunction

    // exp(-de*inv_temp) in Q16
    function automatic longint unsigned boltzmann_q16(int de14);
        longint unsigned x, y, n, f, z, t, p;
        x = longint'(de14) * temp_recip;
        y = (x * 64'd94548) >> 16;
        n = y >> 22;
        f = y & ((64'd1 << 22) - 1);
        if (n >= 17)
            return 0;
        z = (f * 64'd744261118) >> 22;
        t = 64'd1 << 30;
        for (int k = 7; k >= 1; k--)
        begin
            p = ((z * t) >> 30) / k;
            t = (p >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - p;
        end
        return t >> (14 + n);
    endfunction

    function automatic int site_idx(int r, int c);
        return ((r + N_SIDE) % N_SIDE) * N_SIDE + ((c + N_SIDE) % N_SIDE);
    endfunction

    // work out one result and update the lattice copy
    function automatic site_result_t predict_update(move_t mv);
        site_result_t res;
        int r, c, e0, e1, de;
        int nb [4];
        logic [15:0] old_a, new_a;
        r = mv.row;
        c = mv.col;
        res = '0;
        if (mv.mode == MODE_LOAD)
            grid_angle[site_idx(r, c)] = mv.load_angle;
        else if (mv.mode == MODE_ATTEMPT)
        begin
            nb[0] = site_idx(r + 1, c);
            nb[1] = site_idx(r - 1, c);
            nb[2] = site_idx(r, c + 1);
            nb[3] = site_idx(r, c - 1);
            old_a = grid_angle[site_idx(r, c)];
            new_a = old_a + mv.perturbation;
            e0 = 0;
            e1 = 0;
            for (int k = 0; k < 4; k++)
            begin
                e0 += bond_q14(old_a, grid_angle[nb[k]]);
                e1 += bond_q14(new_a, grid_angle[nb[k]]);
            end
            de = e1 - e0;
            if (de <= 0 || boltzmann_q16(de) >= mv.uniform_draw)
                res.accepted = 1'b1;
            if (res.accepted)
                grid_angle[site_idx(r, c)] = new_a;
            res.energy_change = 16'(de / 4);
            attempt_count++;
            if (res.accepted)
                accept_count++;
        end
        res.site_angle = grid_angle[site_idx(r, c)];
        return res;
    endfunction

    // driver: offers the oldest pending item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            mode         <= MODE_LOAD;
            row          <= '0;
            col          <= '0;
            load_angle   <= '0;
            perturbation <= '0;
            uniform_draw <= '0;
        end
        else
        begin
            automatic bit done_beat = in_valid && in_ready;
            if (done_beat)
            begin
                expected_results = {expected_results,
                                    predict_update(move_queue.pop_front())};
            end
            if ((!in_valid || done_beat) && move_queue.size() > 0
                && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid     <= 1'b1;
                mode         <= move_queue[0].mode;
                row          <= move_queue[0].row;
                col          <= move_queue[0].col;
                load_angle   <= move_queue[0].load_angle;
                perturbation <= move_queue[0].perturbation;
                uniform_draw <= move_queue[0].uniform_draw;
            end
            else if (done_beat)
                in_valid <= 1'b0;
        end
    end

    // monitor and output stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                result_count++;
                if (expected_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t unexpected beat: acc %0d angle %0d de %0d", $time,
                             accepted, site_angle, energy_change);
                end
                else
                begin
                    automatic site_result_t exp_r = expected_results.pop_front();
                    if (exp_r.accepted !== accepted || exp_r.site_angle !== site_angle
                        || exp_r.energy_change !== energy_change)
                    begin
                        error_count++;
                        $display({"%0t mismatch: expected acc %0d angle %0d de %0d,",
                                  " got acc %0d angle %0d de %0d"},
                                 $time, exp_r.accepted, exp_r.site_angle,
                                 exp_r.energy_change, accepted, site_angle, energy_change);
                    end
                end
            end
            if (recv_hold)
                out_ready <= 1'b0;
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off, counted in its own process
    always @(posedge clk)
    begin
        if (recv_hold)
        begin
            recv_hold_cycles++;
            if (recv_hold_cycles >= 400)
                recv_hold <= 1'b0;
        end
    end

    task automatic wait_drained();
        while (move_queue.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_inv_temp(logic [15:0] v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        temp_recip = v;
    endtask

    function automatic move_t mk(logic [1:0] md, int r, int c, logic [15:0] a,
                                 logic [15:0] p, logic [15:0] u);
        move_t mv;
        mv.mode = md;
        mv.row = 8'(r);
        mv.col = 8'(c);
        mv.load_angle = a;
        mv.perturbation = p;
        mv.uniform_draw = u;
        return mv;
    endfunction

    // random item on a fully loaded 4x4 block at the given corner
    function automatic move_t rand_move(int r0, int c0);
        int pick = $urandom_range(99);
        int r = r0 + $urandom_range(3);
        int c = c0 + $urandom_range(3);
        logic [15:0] u = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom);
        logic [15:0] p = ($urandom_range(1)) ? 16'($urandom)
                                             : 16'($signed($urandom_range(4000)) - 2000);
        if (pick < 10)
            return mk(MODE_LOAD, r, c, 16'($urandom), p, u);
        else if (pick < 20)
            return mk(($urandom_range(3) == 0) ? 2'd3 : MODE_READ, r, c, 16'($urandom), p, u);
        return mk(MODE_ATTEMPT, r, c, 16'($urandom), p, u);
    endfunction

    // append one item to the pending list
    task automatic add_move(move_t mv);
        move_queue = {move_queue, mv};
    endtask

    // load a 6x6 patch so every 4x4 interior neighbor is known; wraps at edges
    task automatic load_patch(int r0, int c0);
        for (int r = -1; r <= 4; r++)
            for (int c = -1; c <= 4; c++)
                add_move(mk(MODE_LOAD, (r0 + r + N_SIDE) % N_SIDE,
                            (c0 + c + N_SIDE) % N_SIDE, 16'($urandom), 0, 0));
    endtask

    task automatic run_random(int n, int r0, int c0);
        for (int i = 0; i < n; i++)
            add_move(rand_move(r0, c0));
    endtask

    // stimulus
    initial
    begin
        error_count = 0;
        result_count = 0;
        attempt_count = 0;
        accept_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        recv_hold = 1'b0;
        recv_hold_cycles = 0;
        temp_recip = INV_TEMP_RST;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        fill_cos_table();
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: corner site with wrapped neighbors, field extremes
        add_move(mk(MODE_LOAD, 0, 0, 16'h0000, 0, 0));
        add_move(mk(MODE_LOAD, 1, 0, 16'hFFFF, 0, 0));
        add_move(mk(MODE_LOAD, 255, 0, 16'h8000, 0, 0));
        add_move(mk(MODE_LOAD, 0, 1, 16'h4000, 0, 0));
        add_move(mk(MODE_LOAD, 0, 255, 16'h2AAA, 0, 0));
        add_move(mk(MODE_LOAD, 255, 255, 16'h5555, 0, 0));
        add_move(mk(MODE_READ, 0, 0, 0, 0, 0));
        add_move(mk(2'd3, 255, 255, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        add_move(mk(MODE_ATTEMPT, 0, 0, 0, 16'h7FFF, 16'hFFFF));
        add_move(mk(MODE_ATTEMPT, 0, 0, 0, 16'h8000, 16'h0000));
        add_move(mk(MODE_ATTEMPT, 0, 0, 0, 16'h0000, 16'hFFFF));
        add_move(mk(MODE_ATTEMPT, 0, 0, 0, 16'h0400, 16'h0001));
        add_move(mk(MODE_ATTEMPT, 0, 0, 0, 16'hFC00, 16'h8000));
        add_move(mk(MODE_READ, 0, 0, 0, 0, 0));
        load_patch(100, 200);

        // random phases with changing temperature and idling
        run_random(60, 100, 200);
        write_inv_temp(16'd0);
        run_random(50, 100, 200);
        write_inv_temp(16'hFFFF);
        send_idle_pct = 87;
        run_random(40, 100, 200);
        write_inv_temp(16'd64);
        send_idle_pct = 0;
        recv_stall_pct = 87;
        load_patch(254, 254);
        run_random(60, 254, 254);
        write_inv_temp(16'd1);
        send_idle_pct = 14;
        recv_stall_pct = 14;
        run_random(60, 100, 200);
        // sender waits for the block to drain before the hold-off phase
        wait_drained();
        write_inv_temp(16'd300);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        recv_hold_cycles = 0;
        recv_hold <= 1'b1;
        run_random(60, 254, 254);
        write_inv_temp(16'd2048);
        run_random(60, 100, 200);
        wait_drained();

        $display("covered %0d results, %0d attempts with %0d kept, seven temperature settings",
                 result_count, attempt_count, accept_count);
        if (error_count == 0)
            $display("PASS lattice_metropolis_update");
        else
            $display("FAIL lattice_metropolis_update");
        $finish;
    end

    // run limit
    initial
    begin
        #20ms;
        $display("FAIL lattice_metropolis_update");
        $finish;
    end

endmodule

// ----- files.f -----
sv/lmu_pkg.sv
sv/lmu_ram.sv
sv/lmu_mul.sv
sv/lmu_bond.sv
sv/lattice_metropolis_update.sv
sv/lmu_checker.sv
verif/tb_top.sv
